/* src/pcd_pkg.sv */
// Shared types and constants of the PI position controller with dead band.
`timescale 1ns / 1ps

package pcd_pkg;

  // Default width of the integral accumulator.
  localparam int ACCUM_BITS_DEF = 48;

  // Field widths of the channels and the configuration port.
  localparam int SLIDER_W  = 8;
  localparam int POS_W     = 16;
  localparam int DRIVE_W   = 16;
  localparam int MAG_W     = 15;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 40;

  // The accumulator magnitude is split into two 32-bit words for the gain product.
  localparam int MUL_WORD_W = 32;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_LEFT_END   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_RIGHT_END  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_PROP_GAIN  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_INTEG_GAIN = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_TICK       = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_DEAD_BAND  = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_POWER_LIM  = 3'd6;

  // Register values after reset.
  localparam logic [15:0] PROP_GAIN_RST  = 16'd2621;
  localparam logic [15:0] INTEG_GAIN_RST = 16'd1311;
  localparam logic [15:0] TICK_RST       = 16'd655;
  localparam logic [14:0] DEAD_BAND_RST  = 15'd50;
  localparam logic [14:0] POWER_LIM_RST  = 15'd150;

  // Saturation bounds of the drive.
  localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = 16'sh7fff;
  localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = 16'sh8000;
  localparam logic [14:0] SCALED_MAX = 15'h7fff;

  // One load strobe per datapath step, issued by the controller.
  typedef struct packed {
    logic ld_in;
    logic ld_quot;
    logic ld_scale;
    logic ld_err;
    logic ld_mul;
    logic ld_acc;
    logic ld_abs;
    logic ld_imul;
    logic ld_prod;
    logic ld_sum;
    logic ld_drive;
    logic ld_out;
  } cmd_t;

endpackage

/* src/pcd_ctrl.sv */
// Sequencer of the PI controller: steps the datapath and owns the channel handshakes.
`timescale 1ns / 1ps

module pcd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  output pcd_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_QUOT, S_SCALE, S_ERR, S_MUL, S_ACC, S_ABS,
    S_IMUL, S_PROD, S_SUM, S_DRIVE, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // The output register can take a new beat when empty or being emptied.
  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.ld_in = 1'b1;
          state_nxt = S_QUOT;
        end
      end
      S_QUOT:  begin cmd.ld_quot  = 1'b1; state_nxt = S_SCALE; end
      S_SCALE: begin cmd.ld_scale = 1'b1; state_nxt = S_ERR;   end
      S_ERR:   begin cmd.ld_err   = 1'b1; state_nxt = S_MUL;   end
      S_MUL:   begin cmd.ld_mul   = 1'b1; state_nxt = S_ACC;   end
      S_ACC:   begin cmd.ld_acc   = 1'b1; state_nxt = S_ABS;   end
      S_ABS:   begin cmd.ld_abs   = 1'b1; state_nxt = S_IMUL;  end
      S_IMUL:  begin cmd.ld_imul  = 1'b1; state_nxt = S_PROD;  end
      S_PROD:  begin cmd.ld_prod  = 1'b1; state_nxt = S_SUM;   end
      S_SUM:   begin cmd.ld_sum   = 1'b1; state_nxt = S_DRIVE; end
      S_DRIVE: begin cmd.ld_drive = 1'b1; state_nxt = S_OUT;   end
      S_OUT: begin
        if (out_free) begin
          cmd.ld_out    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* src/pcd_dp.sv */
// Datapath of the PI controller: configuration registers, arithmetic steps, integral state.
`timescale 1ns / 1ps

module pcd_dp #(
  parameter int ACCUM_BITS = pcd_pkg::ACCUM_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [pcd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [pcd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic [pcd_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  pcd_pkg::cmd_t                     cmd,
  output logic [pcd_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  localparam int SUM_W = ((ACCUM_BITS > 34) ? ACCUM_BITS : 34) + 1;
  localparam int WIDE_W = 2 * pcd_pkg::MUL_WORD_W;

  // Configuration registers.
  logic signed [15:0] left_r, right_r;
  logic [15:0] kp_r, ki_r, tick_r;
  logic [14:0] db_r, pl_r;

  // Step registers.
  logic [15:0] span_r, span_nxt;
  logic [7:0] slider_r;
  logic signed [15:0] meas_r;
  logic [8:0] q_r, q_nxt;
  logic [14:0] scaled_r, scaled_nxt;
  logic signed [17:0] err_r, err_nxt;
  logic dead_r, dead_nxt;
  logic signed [33:0] inc_r, inc_nxt, p_r, p_nxt;
  logic signed [ACCUM_BITS-1:0] acc_r, acc_nxt;
  logic [ACCUM_BITS-1:0] imag_r, imag_nxt;
  logic neg_r;
  logic [47:0] lo_r, hi_r;
  logic [79:0] prod_r, prod_nxt;
  logic signed [51:0] sum_r, sum_nxt;
  logic sat_r, sat_nxt;
  logic signed [15:0] drive_r, drive_nxt;
  logic [pcd_pkg::OUT_TDATA_W-1:0] out_r, out_nxt;

  // Scratch signals.
  logic signed [16:0] diff;
  logic [16:0] span_p1;
  logic [24:0] recip;
  logic [16:0] scaled_full;
  logic [16:0] abs_err;
  logic signed [SUM_W-1:0] acc_sum;
  logic [SUM_W-ACCUM_BITS:0] acc_top;
  logic [WIDE_W-1:0] imag_wide;
  logic signed [51:0] iterm, p_ext;
  logic [51:0] sabs;
  logic [19:0] smag;
  logic [15:0] mag_full;
  logic [14:0] mag;
  logic move_right;

  assign out_tdata = out_r;

  // Span of travel and divide by 255: floor(x / 255) = ((x + 1) * 257) >> 16 for 16-bit x.
  assign diff     = 17'(left_r) - 17'(right_r);
  assign span_nxt = diff[16] ? 16'(-diff) : diff[15:0];
  assign span_p1  = 17'(span_r) + 17'd1;
  assign recip    = {span_p1, 8'd0} + 25'(span_p1);
  assign q_nxt    = recip[24:16];

  assign scaled_full = 17'(q_r) * 17'(slider_r);
  assign scaled_nxt  = (scaled_full > 17'(pcd_pkg::SCALED_MAX)) ? pcd_pkg::SCALED_MAX
                                                              : scaled_full[14:0];
  assign err_nxt = $signed({3'b000, scaled_r}) - 18'(meas_r);

  // Dead band test and the two error products.
  assign abs_err  = err_r[17] ? 17'(-err_r) : 17'(err_r);
  assign dead_nxt = abs_err < {2'b00, db_r};
  assign inc_nxt  = 34'(err_r) * 34'($signed({1'b0, tick_r}));
  assign p_nxt    = dead_nxt ? '0 : 34'(err_r) * 34'($signed({1'b0, kp_r}));

  // Integral update, saturating at the accumulator width.
  assign acc_sum = SUM_W'(acc_r) + SUM_W'(inc_r);
  assign acc_top = acc_sum[SUM_W-1:ACCUM_BITS-1];
  always_comb begin
    if (dead_r) begin
      acc_nxt = '0;
    end else if ((&acc_top) || (~|acc_top)) begin
      acc_nxt = acc_sum[ACCUM_BITS-1:0];
    end else if (acc_sum[SUM_W-1]) begin
      acc_nxt = {1'b1, {(ACCUM_BITS-1){1'b0}}};
    end else begin
      acc_nxt = {1'b0, {(ACCUM_BITS-1){1'b1}}};
    end
  end

  assign imag_nxt  = acc_r[ACCUM_BITS-1] ? (~acc_r + 1'b1) : acc_r;
  assign imag_wide = WIDE_W'(imag_r);
  assign prod_nxt  = {hi_r, 32'd0} + 80'(lo_r);

  // The integral term saturates the drive once its product reaches 2^50.
  assign sat_nxt = |prod_r[79:50];
  assign iterm   = neg_r ? -$signed({2'b00, prod_r[49:0]}) : $signed({2'b00, prod_r[49:0]});
  assign p_ext   = $signed({{2{p_r[33]}}, p_r, 16'd0});
  assign sum_nxt = p_ext + iterm;

  // Truncate toward zero by working on the magnitude.
  assign sabs = sum_r[51] ? 52'(-sum_r) : 52'(sum_r);
  assign smag = sabs[51:32];
  always_comb begin
    if (sat_r) begin
      drive_nxt = neg_r ? pcd_pkg::DRIVE_MIN : pcd_pkg::DRIVE_MAX;
    end else if (sum_r[51]) begin
      drive_nxt = (smag > 20'd32768) ? pcd_pkg::DRIVE_MIN : 16'(20'd0 - smag);
    end else begin
      drive_nxt = (smag > 20'd32767) ? pcd_pkg::DRIVE_MAX : smag[15:0];
    end
  end

  assign mag_full   = drive_r[15] ? 16'(16'd0 - drive_r) : drive_r;
  assign mag        = (mag_full > {1'b0, pl_r}) ? pl_r : mag_full[14:0];
  assign move_right = drive_r[15] || (drive_r == '0);
  assign out_nxt    = {7'd0, dead_r, mag, move_right, drive_r};

  // Configuration registers and the integral, which reset clears.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r  <= '0;
      right_r <= '0;
      kp_r    <= pcd_pkg::PROP_GAIN_RST;
      ki_r    <= pcd_pkg::INTEG_GAIN_RST;
      tick_r  <= pcd_pkg::TICK_RST;
      db_r    <= pcd_pkg::DEAD_BAND_RST;
      pl_r    <= pcd_pkg::POWER_LIM_RST;
      acc_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_addr)
          pcd_pkg::REG_LEFT_END:   left_r  <= cfg_wdata;
          pcd_pkg::REG_RIGHT_END:  right_r <= cfg_wdata;
          pcd_pkg::REG_PROP_GAIN:  kp_r    <= cfg_wdata;
          pcd_pkg::REG_INTEG_GAIN: ki_r    <= cfg_wdata;
          pcd_pkg::REG_TICK:       tick_r  <= cfg_wdata;
          pcd_pkg::REG_DEAD_BAND:  db_r    <= cfg_wdata[14:0];
          pcd_pkg::REG_POWER_LIM:  pl_r    <= cfg_wdata[14:0];
          default: ;
        endcase
      end
      if (cmd.ld_acc) begin
        acc_r <= acc_nxt;
      end
    end
  end

  // Payload registers of the steps.
  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      slider_r <= in_tdata[7:0];
      meas_r   <= in_tdata[23:8];
      span_r   <= span_nxt;
    end
    if (cmd.ld_quot)  q_r      <= q_nxt;
    if (cmd.ld_scale) scaled_r <= scaled_nxt;
    if (cmd.ld_err)   err_r    <= err_nxt;
    if (cmd.ld_mul) begin
      dead_r <= dead_nxt;
      inc_r  <= inc_nxt;
      p_r    <= p_nxt;
    end
    if (cmd.ld_abs) begin
      imag_r <= imag_nxt;
      neg_r  <= acc_r[ACCUM_BITS-1];
    end
    if (cmd.ld_imul) begin
      lo_r <= 48'(imag_wide[31:0]) * 48'(ki_r);
      hi_r <= 48'(imag_wide[63:32]) * 48'(ki_r);
    end
    if (cmd.ld_prod) prod_r <= prod_nxt;
    if (cmd.ld_sum) begin
      sum_r <= sum_nxt;
      sat_r <= sat_nxt;
    end
    if (cmd.ld_drive) drive_r <= drive_nxt;
    if (cmd.ld_out)   out_r   <= out_nxt;
  end

endmodule

/* src/pi_position_controller_deadband.sv */
// Top level of the PI position controller with dead band and power clamp.
`timescale 1ns / 1ps

// Once per control tick the block takes one input beat carrying a slider reference
// and a measured encoder position, and returns one output beat with the signed drive,
// a direction bit, the drive magnitude clamped to the power limit and a dead-band flag.
// The reference is scaled to encoder units by the integer span of travel over 255.
// Configuration goes through the plain cfg_ port; the user must write it only while no
// beat is in flight, since the block does not enforce this. A beat is accepted only
// while the sequencer is idle. The sequencer then walks the datapath through eleven
// steps (scale, error, products, integral update, gain product split into two 32 by
// 16 multiplies, sum, saturation) and loads the output register in the last step,
// then returns to idle; a new beat is taken only once the current one has finished.
// The output register parts the two sides: a stalled receiver holds the finished beat
// while the next item is accepted and computed, and that item waits in its last step
// until the register empties. Reset sets the sequencer idle, empties the output
// register, returns all configuration registers to their defaults and clears the
// integral.

module pi_position_controller_deadband #(
  parameter int ACCUM_BITS = pcd_pkg::ACCUM_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [pcd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [pcd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // Fields from bit 0: slider_ref[7:0], measured_pos[23:8].
  input  logic [pcd_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // Fields from bit 0: signed_drive[15:0], move_right[16], drive_magnitude[31:17],
  // in_dead_band[32], zero fill above.
  output logic [pcd_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  pcd_pkg::cmd_t cmd;

  pcd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  pcd_dp #(
    .ACCUM_BITS (ACCUM_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .out_tdata (out_tdata)
  );

  // Inside the dead band both error and integral are zero, so the drive is zero.
  a_dead_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[32] |-> (out_tdata[15:0] == 16'd0) && out_tdata[16])
    else $error("dead-band beat carries a nonzero drive");

  // A zero drive has zero magnitude.
  a_zero_mag : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[15:0] == 16'd0) |-> (out_tdata[31:17] == 15'd0))
    else $error("zero drive with nonzero magnitude");

  // Once a beat is accepted the sequencer is busy in the next cycle.
  a_busy : assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted again while an item is in flight");

  // A new result appears only as the sequencer returns to idle.
  a_result_idle : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> in_tready)
    else $error("result loaded while the sequencer is not finishing");

endmodule

/* bench/testbench.sv */
// Self-checking bench for the PI position controller: directed, random and windup runs.
`timescale 1ns / 1ps

// The bench drives control ticks into the controller as stream beats and keeps its own
// copy of the control law, the integral state and the register file. Every accepted input
// beat adds one predicted result to a queue; every output beat is compared field by field
// with the oldest prediction. Registers are only rewritten once the queue has drained and
// the block has had time to settle.
//
// The run has three parts:
//   - a short scripted walk through reset values, error and position extremes, the dead
//     band edges, a zero dead band, zero gains, a zero power limit, drive saturation in
//     both directions and the ignored register index;
//   - random phases, each with a freshly drawn register set, mostly feeding positions
//     close to the scaled reference so that the dead band edges are hit often;
//   - a windup run with the integral gain at one count, where the drive reads out the
//     top of the integral as it climbs at its fastest rate and then falls back again.
module testbench;

  localparam int ACC_W = pcd_pkg::ACCUM_BITS_DEF;
  // Index 7 is not a register; writes to it must leave everything unchanged.
  localparam logic [pcd_pkg::CFG_ADDR_W-1:0] REG_UNUSED = 3'd7;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_BEATS = 100;
  localparam int WINDUP_BEATS = 48;
  localparam int UNWIND_BEATS = 24;

  typedef longint unsigned u64_t;

  // Register file as the controller sees it.
  typedef struct {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic [15:0]        kp;
    logic [15:0]        ki;
    logic [15:0]        dt;
    logic [14:0]        db;
    logic [14:0]        pl;
  } ctl_regs_t;

  // One output beat, unpacked.
  typedef struct packed {
    logic signed [15:0] drive;
    logic               move_right;
    logic [14:0]        mag;
    logic               dead;
  } drive_result_t;

  // One scripted tick: register set to use, reference, position, repeat count, and
  // whether the result is the plain "inside dead band, nothing driven" answer.
  typedef struct {
    int       setting;
    bit [7:0] slider;
    int       meas;
    int       reps;
    bit       quiet;
  } script_row_t;

  localparam drive_result_t QUIET = '{drive: 16'sd0, move_right: 1'b1, mag: 15'd0,
                                      dead: 1'b1};

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_wr_en;
  logic [pcd_pkg::CFG_ADDR_W-1:0]  cfg_addr;
  logic [pcd_pkg::CFG_DATA_W-1:0]  cfg_wdata;
  logic                            in_tvalid;
  logic                            in_tready;
  // Fields from bit 0: slider_ref[7:0], measured_pos[23:8].
  logic [pcd_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic                            out_tvalid;
  logic                            out_tready;
  // Fields from bit 0: signed_drive[15:0], move_right[16], drive_magnitude[31:17],
  // in_dead_band[32], zero fill above.
  logic [pcd_pkg::OUT_TDATA_W-1:0] out_tdata;

  // Bench copy of the controller state.
  ctl_regs_t     regs;
  longint        integ_acc;
  drive_result_t expected_q[$];

  // When set, neither side inserts idle cycles.
  bit steady;
  int errors;
  int beats_sent;
  int beats_checked;
  int settings_used;

  // Register sets of the scripted part. Entry 0 is the reset state and is never written.
  ctl_regs_t presets [4] = '{
    '{0, 0, 2621, 1311, 655, 50, 150},
    // Widest span, full gains, no dead band, no clamp: drive pinned by the integral.
    '{32767, -32768, 65535, 65535, 65535, 0, 32767},
    // Reversed span, integral only, one-count dead band, zero power limit.
    '{-32768, 32767, 0, 65535, 65535, 1, 0},
    // Span of exactly 255, P only, widest dead band.
    '{0, 255, 65535, 0, 0, 32767, 32767}
  };

  script_row_t script [16] = '{
    // Reset values: zero span, so the reference scales to zero.
    '{0, 0, 0, 1, 1},
    '{0, 255, 49, 1, 1},
    '{0, 128, -49, 1, 1},
    // Error exactly on the dead band edge counts as outside.
    '{0, 7, 50, 1, 0},
    '{0, 0, -32768, 1, 0},
    '{0, 255, 32767, 1, 0},
    '{0, 0, 0, 1, 1},
    // Largest positive error until the integral term saturates the drive.
    '{1, 255, -32768, 5, 0},
    // Zero error with a zero dead band is still outside it.
    '{1, 0, 0, 1, 0},
    '{2, 0, 0, 1, 1},
    // Largest negative error until the drive hits its most negative value.
    '{2, 0, 32767, 9, 0},
    // Reference clamped to 32767, equal to the position.
    '{2, 255, 32767, 1, 1},
    '{2, 0, -1, 1, 0},
    '{3, 255, -32768, 1, 0},
    '{3, 100, 100, 1, 1},
    '{3, 0, 32767, 1, 0}
  };

  pi_position_controller_deadband #(
    .ACCUM_BITS(ACC_W)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Reference in encoder units: whole counts per slider step, times the slider.
  function automatic longint scaled_ref(bit [7:0] slider);
    longint span;
    longint s;
    span = longint'(regs.left) - longint'(regs.right);
    if (span < 0) begin
      span = -span;
    end
    s = (span / 255) * longint'(slider);
    if (s > 32767) begin
      s = 32767;
    end
    return s;
  endfunction

  // One control tick: updates the bench integral and returns the result beat.
  function automatic drive_result_t pi_law_step(bit [7:0] slider, logic signed [15:0] meas);
    longint err;
    longint abs_err;
    longint inc;
    longint hi;
    longint lo;
    longint p_term;
    longint iterm;
    longint sum;
    longint d;
    longint mag;
    u64_t   imag;
    u64_t   smag;
    u64_t   ki_u;
    drive_result_t r;
    err = scaled_ref(slider) - longint'(meas);
    abs_err = (err < 0) ? -err : err;
    r.dead = (abs_err < longint'(regs.db));
    if (r.dead) begin
      err = 0;
      integ_acc = 0;
    end else begin
      inc = err * longint'(regs.dt);
      hi = (longint'(1) <<< (ACC_W - 1)) - 1;
      lo = -hi - 1;
      if (inc > 0 && integ_acc > hi - inc) begin
        integ_acc = hi;
      end else if (inc < 0 && integ_acc < lo - inc) begin
        integ_acc = lo;
      end else begin
        integ_acc = integ_acc + inc;
      end
    end
    p_term = err * longint'(regs.kp) * 65536;
    imag = (integ_acc < 0) ? u64_t'(-integ_acc) : u64_t'(integ_acc);
    ki_u = u64_t'(regs.ki);
    // A large enough integral term pins the drive; the P term cannot pull it back.
    if (ki_u != 0 && imag >= ((u64_t'(1) << 50) + ki_u - 1) / ki_u) begin
      d = (integ_acc < 0) ? -32768 : 32767;
    end else begin
      iterm = longint'(imag * ki_u);
      if (integ_acc < 0) begin
        iterm = -iterm;
      end
      sum = p_term + iterm;
      smag = (sum < 0) ? u64_t'(-sum) : u64_t'(sum);
      smag = smag >> 32;
      if (sum < 0) begin
        d = (smag > 32768) ? -32768 : -longint'(smag);
      end else begin
        d = (smag > 32767) ? 32767 : longint'(smag);
      end
    end
    mag = (d > 0) ? d : -d;
    if (mag > longint'(regs.pl)) begin
      mag = longint'(regs.pl);
    end
    r.drive = d[15:0];
    r.move_right = (d <= 0);
    r.mag = mag[14:0];
    return r;
  endfunction

  function automatic int idle_gap();
    return steady ? 0 : int'($urandom_range(0, 4));
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input longint got, input longint want);
    if (got != want) begin
      report_mismatch($sformatf("result %0d field %s: got %0d, expected %0d",
                                beats_checked, name, got, want));
    end
  endtask

  // Write one register; the caller lowers the write enable after its last write.
  task automatic write_reg(input logic [pcd_pkg::CFG_ADDR_W-1:0] idx, input logic [15:0] val);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // Load a full register set. Bit 15 of the words written to the 15-bit registers is set at
  // random, since the block must drop it. The unused index gets random data on every call.
  task automatic apply_config(input ctl_regs_t s);
    write_reg(pcd_pkg::REG_LEFT_END, s.left);
    write_reg(pcd_pkg::REG_RIGHT_END, s.right);
    write_reg(pcd_pkg::REG_PROP_GAIN, s.kp);
    write_reg(pcd_pkg::REG_INTEG_GAIN, s.ki);
    write_reg(pcd_pkg::REG_TICK, s.dt);
    write_reg(pcd_pkg::REG_DEAD_BAND, {1'($urandom), s.db});
    write_reg(pcd_pkg::REG_POWER_LIM, {1'($urandom), s.pl});
    write_reg(REG_UNUSED, 16'($urandom));
    cfg_wr_en <= 1'b0;
    regs = s;
    settings_used++;
  endtask

  // Offer one tick and wait for it to be taken. tvalid is left high on return, so a
  // following beat with no gap goes out back to back.
  task automatic send_beat(input bit [7:0] slider, input logic signed [15:0] meas,
                           input bit quiet);
    int gap;
    drive_result_t want;
    gap = idle_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= {meas, slider};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (in_tready !== 1'b1);
    want = pi_law_step(slider, meas);
    expected_q.push_back(quiet ? QUIET : want);
    beats_sent++;
  endtask

  // Stop offering, let every outstanding result come back, then let the block settle.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] pick16(input int lo_v, input int hi_v);
    case ($urandom_range(0, 5))
      0: return lo_v[15:0];
      1: return hi_v[15:0];
      default: return 16'($urandom);
    endcase
  endfunction

  // Random register set, with the extremes drawn often and the dead band and power
  // limit kept mostly small so that both sides of them are seen.
  function automatic ctl_regs_t random_regs();
    ctl_regs_t s;
    s.left  = pick16(-32768, 32767);
    s.right = pick16(-32768, 32767);
    s.kp    = pick16(0, 65535);
    s.ki    = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 2000)) : pick16(0, 65535);
    s.dt    = pick16(0, 65535);
    case ($urandom_range(0, 5))
      0: s.db = 15'd0;
      1: s.db = 15'd32767;
      2: s.db = 15'($urandom);
      default: s.db = 15'($urandom_range(0, 300));
    endcase
    case ($urandom_range(0, 5))
      0: s.pl = 15'd0;
      1: s.pl = 15'd32767;
      2: s.pl = 15'($urandom);
      default: s.pl = 15'($urandom_range(0, 2000));
    endcase
    return s;
  endfunction

  // Random ticks. Most positions sit near the scaled reference, a fair share right on
  // the dead band edges; the rest are anywhere, or at the field extremes.
  task automatic run_random(input int count);
    bit [7:0]           slider;
    logic signed [15:0] meas;
    longint             target;
    longint             db;
    int                 kind;
    for (int i = 0; i < count; i++) begin
      slider = 8'($urandom_range(0, 255));
      kind = $urandom_range(0, 9);
      db = longint'(regs.db);
      if (kind <= 5) begin
        if (kind == 0) begin
          case ($urandom_range(0, 3))
            0: target = db;
            1: target = -db;
            2: target = db - 1;
            default: target = 1 - db;
          endcase
        end else begin
          target = longint'($urandom_range(0, 2 * (int'(db) + 3))) - (db + 3);
        end
        target = scaled_ref(slider) + target;
        if (target > 32767) target = 32767;
        if (target < -32768) target = -32768;
        meas = target[15:0];
      end else if (kind <= 8) begin
        meas = 16'($urandom);
      end else begin
        slider = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        case ($urandom_range(0, 3))
          0: meas = -16'sd32768;
          1: meas = 16'sd32767;
          2: meas = 16'sd0;
          default: meas = -16'sd1;
        endcase
      end
      send_beat(slider, meas, 1'b0);
    end
  endtask

  // Result side: stall a random number of cycles before each beat, then take it and
  // compare it with the oldest prediction.
  initial begin
    int            hold;
    drive_result_t want;
    forever begin
      hold = idle_gap();
      if (hold > 0) begin
        out_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result beat 0x%0h arrived with nothing expected",
                                  out_tdata));
      end else begin
        want = expected_q.pop_front();
        check_field("signed_drive", longint'($signed(out_tdata[15:0])), longint'(want.drive));
        check_field("move_right", longint'(out_tdata[16]), longint'(want.move_right));
        check_field("drive_magnitude", longint'(out_tdata[31:17]), longint'(want.mag));
        check_field("in_dead_band", longint'(out_tdata[32]), longint'(want.dead));
      end
      beats_checked++;
    end
  end

  // Main sequence.
  initial begin
    int cur_setting;
    rst_n      <= 1'b0;
    cfg_wr_en  <= 1'b0;
    cfg_addr   <= '0;
    cfg_wdata  <= '0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    steady        = 1'b0;
    errors        = 0;
    beats_sent    = 0;
    beats_checked = 0;
    settings_used = 1;
    regs          = presets[0];
    integ_acc     = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Scripted part: the register set changes only between groups of rows.
    cur_setting = 0;
    foreach (script[r]) begin
      if (script[r].setting != cur_setting) begin
        drain();
        cur_setting = script[r].setting;
        apply_config(presets[cur_setting]);
      end
      repeat (script[r].reps) begin
        send_beat(script[r].slider, script[r].meas[15:0], script[r].quiet);
      end
    end
    drain();

    // Random phases; every fourth one runs with no idle cycles on either side.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      steady = (ph % 4 == 3);
      apply_config(random_regs());
      run_random(PHASE_BEATS);
      drain();
    end
    steady = 1'b0;

    // Windup: with the integral gain at one count the drive reads out the top of the
    // integral, so it counts up by about one per tick at the largest error and then
    // falls back by about half a count per tick.
    apply_config('{32767, -32768, 0, 1, 65535, 0, 32767});
    repeat (WINDUP_BEATS) send_beat(8'd255, -16'sd32768, 1'b0);
    repeat (UNWIND_BEATS) send_beat(8'd0, 16'sd32767, 1'b0);
    drain();

    $display("Covered %0d ticks over %0d register settings, %0d results compared,",
             beats_sent, settings_used, beats_checked);
    $display("including dead band edges, drive saturation and integral windup.");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("[pi_position_controller_deadband] OK");
    end else begin
      $display("[pi_position_controller_deadband] ERROR");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin
    #2_000_000;
    $display("Timed out with %0d results still outstanding.", expected_q.size());
    $display("[pi_position_controller_deadband] ERROR");
    $finish;
  end

endmodule

/* pi_position_controller_deadband.f */
src/pcd_pkg.sv
src/pcd_ctrl.sv
src/pcd_dp.sv
src/pi_position_controller_deadband.sv
bench/testbench.sv
